// ----- hw/rtl/bst_pkg.sv -----
package bst_pkg;

  localparam int TABLE_ENTRIES = 8;
  localparam int SOLUTION_BITS = 64;

  localparam int IN_BITS_W  = 64;
  localparam int ENERGY_W   = 32;
  localparam int HIT_W      = 16;
  localparam int STATUS_W   = 3;
  localparam int OUT_SLOT_W = 3;
  localparam int SLOT_W     = $clog2(TABLE_ENTRIES);

  localparam logic signed [ENERGY_W-1:0] ENERGY_RESET = {1'b1, {(ENERGY_W-1){1'b0}}};
  localparam logic [HIT_W-1:0]           HIT_MAX      = '1;
  localparam logic [HIT_W-1:0]           HIT_ONE      = HIT_W'(1);

  typedef enum logic [STATUS_W-1:0] {
    STAT_REJECT       = 3'd0,
    STAT_NEW_BEST     = 3'd1,
    STAT_DUPLICATE    = 3'd2,
    STAT_EQUAL_ENERGY = 3'd3,
    STAT_NEW_ENERGY   = 3'd4
  } status_t;

  typedef struct packed {
    logic [IN_BITS_W-1:0]       solution_bits;
    logic signed [ENERGY_W-1:0] energy;
  } sol_in_t;

  typedef struct packed {
    status_t                status;
    logic [HIT_W-1:0]       hit_count;
    logic                   equals_best;
    logic [OUT_SLOT_W-1:0]  slot;
  } sol_out_t;

  typedef struct packed {
    logic signed [ENERGY_W-1:0] energy;
    logic [SOLUTION_BITS-1:0]   bits;
    logic [HIT_W-1:0]           hit;
  } entry_t;

  localparam entry_t ENTRY_RESET = '{energy: ENERGY_RESET, bits: '0, hit: '0};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TAIL,
    ST_WRITE,
    ST_DONE
  } state_t;

endpackage

// ----- hw/rtl/best_solutions_table.sv -----
// Table of the best TABLE_ENTRIES candidate solutions, ranked by energy (highest first, lower
// slot first among equal energies). Each input word (bit vector plus signed Q16.16 energy)
// yields exactly one output word: status (rejected, new best, duplicate, unique at an existing
// energy, new energy), the hit count of the entry touched, whether the energy equals the best in
// the table, and the slot number modulo 8. Insertions overwrite the lowest-ranked slot; hit
// counts saturate at 65535. Entries live in one synchronous single-port-read memory which is
// swept one entry per cycle; an item goes through the sweep, the registered read, the
// write-back and the load of the output register before the next word can be taken. A
// finished word waits in the output register while the next input word is accepted; if the
// receiver still holds the previous word when the next one is finished, the load and the
// input stall until it is taken. Entries never written read as their reset value (most
// negative energy, zero vector, zero count) through per-entry valid bits cleared at reset,
// so no clearing pass is needed.
module best_solutions_table (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  bst_pkg::sol_in_t  in_word,
  output logic              out_valid,
  input  logic              out_ready,
  output bst_pkg::sol_out_t out_word
);
  import bst_pkg::*;

  // Control
  state_t state_r, state_nxt;
  logic   in_accept;
  logic   rd_en, res_load, out_load, mem_we;

  // Table storage: one memory of entries plus a valid bit per entry
  entry_t                   mem_r [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_r;
  entry_t                   rd_q_r;
  logic                     rd_ent_vld_r;
  logic                     rd_vld_r;
  logic [SLOT_W-1:0]        rd_idx_r;
  logic [SLOT_W-1:0]        scan_cnt_r;
  logic                     scan_last;
  entry_t                   ent;

  // Held item
  sol_in_t                    item_r;
  logic signed [ENERGY_W-1:0] e_val;
  logic [SOLUTION_BITS-1:0]   bits_val;

  // Sweep results
  logic signed [ENERGY_W-1:0] max_r, min_r;
  logic [SLOT_W-1:0]          worst_r;
  logic                       match_r, any_eq_r;
  logic [SLOT_W-1:0]          match_slot_r;
  logic [HIT_W-1:0]           match_hit_r;
  logic                       first_ent, ent_eq;

  // Decision
  status_t           dec_status;
  logic [SLOT_W-1:0] dec_slot;
  logic [HIT_W-1:0]  dec_hit;
  logic              dec_best;
  entry_t            wr_entry;
  sol_out_t          res_r, out_word_r;
  logic              out_valid_r;

  assign in_accept = in_valid && in_ready;
  assign e_val     = item_r.energy;
  assign bits_val  = item_r.solution_bits[SOLUTION_BITS-1:0];
  assign scan_last = (scan_cnt_r == SLOT_W'(TABLE_ENTRIES - 1));

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_SCAN;
      ST_SCAN:  if (scan_last) state_nxt = ST_TAIL;
      ST_TAIL:  state_nxt = ST_WRITE;
      ST_WRITE: state_nxt = ST_DONE;
      ST_DONE:  if (out_load) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Per-state strobes. Only one item is in flight, so a write-back can never overlap a read of
  // the same entry: the sweep of the next item starts after the write has landed.
  always_comb begin
    in_ready = 1'b0;
    rd_en    = 1'b0;
    res_load = 1'b0;
    out_load = 1'b0;
    case (state_r)
      ST_IDLE:  in_ready = 1'b1;
      ST_SCAN:  rd_en    = 1'b1;
      ST_WRITE: res_load = 1'b1;
      ST_DONE:  out_load = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  // Substitute the reset value for entries that were never written
  assign ent       = rd_ent_vld_r ? rd_q_r : ENTRY_RESET;
  assign first_ent = (rd_idx_r == '0);
  assign ent_eq    = (ent.energy == e_val);

  // Decide from the sweep results: the lowest-ranked slot is the lowest energy, highest slot
  // among ties; a duplicate is the lowest slot holding the same vector at the same energy.
  always_comb begin
    dec_status = STAT_REJECT;
    dec_slot   = '0;
    dec_hit    = '0;
    dec_best   = 1'b0;
    if (e_val > max_r) begin
      dec_status = STAT_NEW_BEST;
      dec_slot   = worst_r;
      dec_hit    = HIT_ONE;
      dec_best   = 1'b1;
    end else if (!(e_val < min_r)) begin
      dec_best = (e_val == max_r);
      if (match_r) begin
        dec_status = STAT_DUPLICATE;
        dec_slot   = match_slot_r;
        dec_hit    = (match_hit_r == HIT_MAX) ? HIT_MAX : match_hit_r + HIT_ONE;
      end else if (any_eq_r) begin
        dec_status = STAT_EQUAL_ENERGY;
        dec_slot   = worst_r;
        dec_hit    = HIT_ONE;
      end else begin
        dec_status = STAT_NEW_ENERGY;
        dec_slot   = worst_r;
        dec_hit    = HIT_ONE;
      end
    end
  end

  assign mem_we   = res_load && (dec_status != STAT_REJECT);
  assign wr_entry = '{energy: e_val, bits: bits_val, hit: dec_hit};

  // Memory: registered read, single write port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q_r <= mem_r[scan_cnt_r];
    end
    if (mem_we) begin
      mem_r[dec_slot] <= wr_entry;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      rd_vld_r    <= 1'b0;
      scan_cnt_r  <= '0;
      match_r     <= 1'b0;
      any_eq_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      rd_vld_r <= rd_en;
      if (in_accept) begin
        scan_cnt_r <= '0;
      end else if (rd_en) begin
        scan_cnt_r <= scan_cnt_r + SLOT_W'(1);
      end
      if (in_accept) begin
        match_r  <= 1'b0;
        any_eq_r <= 1'b0;
      end else if (rd_vld_r) begin
        if (ent_eq) any_eq_r <= 1'b1;
        if (ent_eq && (ent.bits == bits_val)) match_r <= 1'b1;
      end
      if (mem_we) begin
        valid_r[dec_slot] <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_r <= in_word;
    end
    if (rd_en) begin
      rd_ent_vld_r <= valid_r[scan_cnt_r];
      rd_idx_r     <= scan_cnt_r;
    end
    if (rd_vld_r) begin
      // Track best and worst; ascending sweep with <= lands on the highest slot among ties
      if (first_ent || (ent.energy > max_r)) begin
        max_r <= ent.energy;
      end
      if (first_ent || (ent.energy <= min_r)) begin
        min_r   <= ent.energy;
        worst_r <= rd_idx_r;
      end
      // Keep the first duplicate only
      if (ent_eq && (ent.bits == bits_val) && !match_r) begin
        match_slot_r <= rd_idx_r;
        match_hit_r  <= ent.hit;
      end
    end
    if (res_load) begin
      res_r <= '{status: dec_status, hit_count: dec_hit, equals_best: dec_best,
                 slot: OUT_SLOT_W'(dec_slot)};
    end
    if (out_load) begin
      out_word_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  a_reject_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.status == STAT_REJECT) |->
      (out_word.hit_count == '0) && (out_word.slot == '0) && !out_word.equals_best)
    else $error("rejected word carries a non-zero field");

  a_new_best_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.status == STAT_NEW_BEST) |->
      out_word.equals_best && (out_word.hit_count == HIT_ONE))
    else $error("new best word without best flag or unit count");

  a_new_energy_not_best: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.status == STAT_NEW_ENERGY) |-> !out_word.equals_best)
    else $error("new energy flagged as best");

  a_accept_starts_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r == ST_SCAN) && (scan_cnt_r == '0))
    else $error("sweep did not start from the first entry");

  a_write_marks_valid: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |=> valid_r[$past(dec_slot)])
    else $error("written entry not marked valid");

endmodule

// ----- tb/tb.sv -----
module tb;
  import bst_pkg::*;

  // Allow a margin on top of the time that one word spends inside the block.
  localparam int DRAIN_CYCLES   = 3 * (TABLE_ENTRIES + 4);
  localparam int CYCLE_LIMIT    = 4_000_000;
  localparam int RANDOM_WORDS   = 1550;
  localparam int SQUEEZE_AT     = 500;
  localparam int SQUEEZE_CYCLES = 300;
  localparam int REPORT_CAP     = 100;
  localparam int MAX_GAP        = 10;

  localparam logic signed [ENERGY_W-1:0] E_MIN    = ENERGY_RESET;
  localparam logic signed [ENERGY_W-1:0] E_MIN_P1 = 32'sh8000_0001;
  localparam logic signed [ENERGY_W-1:0] E_MAX    = 32'sh7FFF_FFFF;
  localparam logic signed [ENERGY_W-1:0] E_ONE    = 32'sh0001_0000;  // 1.0
  localparam logic signed [ENERGY_W-1:0] E_TOP    = 32'sh0010_0000;  // 16.0

  localparam sol_out_t UNTYPED = '{STAT_REJECT, 16'd0, 1'b0, 3'd0};

  typedef struct packed {
    logic [IN_BITS_W-1:0]       bits;
    logic signed [ENERGY_W-1:0] energy;
    logic [31:0]                reps;
    logic                       typed;
    sol_out_t                   want;
  } stim_row_t;

  // Rows before OPENING_ROWS run on the freshly reset table, so their results can be
  // typed in. The closing rows push the energy to its top end once the random part
  // is over, since a stored maximum would shut out every later new best.
  localparam int OPENING_ROWS = 17;
  localparam int NUM_ROWS     = 22;

  localparam stim_row_t STIM_ROWS [NUM_ROWS] = '{
    // never-written entries match an all-zero vector at the reset energy
    '{64'h0, E_MIN, 32'd1, 1'b1, '{STAT_DUPLICATE, 16'd1, 1'b1, 3'd0}},
    '{'1, E_TOP, 32'd1, 1'b1, '{STAT_NEW_BEST, 16'd1, 1'b1, 3'd7}},
    '{'1, E_TOP, 32'd1, 1'b1, '{STAT_DUPLICATE, 16'd2, 1'b1, 3'd7}},
    '{64'h5555_5555_5555_5555, E_TOP, 32'd1, 1'b1,
      '{STAT_EQUAL_ENERGY, 16'd1, 1'b1, 3'd6}},
    '{64'hAAAA_AAAA_AAAA_AAAA, 32'sd0, 32'd1, 1'b1,
      '{STAT_NEW_ENERGY, 16'd1, 1'b0, 3'd5}},
    '{64'h1, -32'sd1, 32'd1, 1'b1, '{STAT_NEW_ENERGY, 16'd1, 1'b0, 3'd4}},
    '{64'h2, E_ONE, 32'd1, 1'b1, '{STAT_NEW_ENERGY, 16'd1, 1'b0, 3'd3}},
    '{64'h3, E_MIN_P1, 32'd1, 1'b1, '{STAT_NEW_ENERGY, 16'd1, 1'b0, 3'd2}},
    '{64'h4, E_MIN_P1, 32'd1, 1'b1, '{STAT_EQUAL_ENERGY, 16'd1, 1'b0, 3'd1}},
    // second hit on the first entry
    '{64'h0, E_MIN, 32'd1, 1'b1, '{STAT_DUPLICATE, 16'd2, 1'b0, 3'd0}},
    // unique vector joins the worst run and overwrites that same entry
    '{64'h9, E_MIN, 32'd1, 1'b1, '{STAT_EQUAL_ENERGY, 16'd1, 1'b0, 3'd0}},
    '{64'h0, E_MIN, 32'd1, 1'b0, UNTYPED},
    '{64'h7, -32'sd5, 32'd1, 1'b1, '{STAT_NEW_ENERGY, 16'd1, 1'b0, 3'd0}},
    // below the worst entry
    '{64'h0, E_MIN, 32'd1, 1'b1, '{STAT_REJECT, 16'd0, 1'b0, 3'd0}},
    '{64'hF0, E_MIN_P1, 32'd1, 1'b0, UNTYPED},
    '{'1, E_TOP, 32'd1, 1'b0, UNTYPED},
    '{64'h8000_0000_0000_0001, E_TOP + 32'sd1, 32'd1, 1'b0, UNTYPED},
    // closing rows
    '{'1, E_MAX, 32'd1, 1'b0, UNTYPED},
    '{'1, E_MAX, 32'd1, 1'b0, UNTYPED},
    '{64'h0, E_MAX, 32'd1, 1'b0, UNTYPED},
    '{64'h1, E_MAX - 32'sd1, 32'd1, 1'b0, UNTYPED},
    '{64'h0, E_MIN, 32'd1, 1'b0, UNTYPED}
  };

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  sol_in_t   in_word;
  logic      out_valid;
  logic      out_ready;
  sol_out_t  out_word;

  best_solutions_table u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  // Shadow copy of the table; the ranking is rebuilt from it whenever needed.
  logic signed [ENERGY_W-1:0] tbl_energy [TABLE_ENTRIES];
  logic [SOLUTION_BITS-1:0]   tbl_bits   [TABLE_ENTRIES];
  logic [HIT_W-1:0]           tbl_hits   [TABLE_ENTRIES];

  sol_out_t pending_results [$];
  int       mismatches;
  int       results_seen;
  bit       no_idle;
  bit       squeeze_pending;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Stable ranking: highest energy first, lower slot first among equal energies.
  function automatic void rank_slots(output int order [TABLE_ENTRIES]);
    int key;
    int j;
    for (int i = 0; i < TABLE_ENTRIES; i++) order[i] = i;
    for (int i = 1; i < TABLE_ENTRIES; i++) begin
      key = order[i];
      j = i;
      while (j > 0 && tbl_energy[order[j-1]] < tbl_energy[key]) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = key;
    end
  endfunction

  // Work out the result word for one offered solution and update the shadow table.
  function automatic sol_out_t grade_solution(sol_in_t w);
    logic [SOLUTION_BITS-1:0]   bits;
    logic signed [ENERGY_W-1:0] e;
    int                         order [TABLE_ENTRIES];
    int                         s;
    int                         worst_slot;
    bit                         matched;
    status_t                    st;
    sol_out_t                   r;
    bits = w.solution_bits[SOLUTION_BITS-1:0];
    e = w.energy;
    s = 0;
    matched = 1'b0;
    st = STAT_REJECT;
    rank_slots(order);
    worst_slot = order[TABLE_ENTRIES-1];
    if (e > tbl_energy[order[0]]) begin
      s = worst_slot;
      st = STAT_NEW_BEST;
    end else if (e >= tbl_energy[worst_slot]) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (tbl_energy[order[i]] == e) begin
          // search only the run of entries at this energy
          for (int j = i; j < TABLE_ENTRIES; j++) begin
            if (tbl_energy[order[j]] != e) break;
            if (tbl_bits[order[j]] == bits) begin
              s = order[j];
              matched = 1'b1;
              break;
            end
          end
          if (matched) begin
            st = STAT_DUPLICATE;
          end else begin
            s = worst_slot;
            st = STAT_EQUAL_ENERGY;
          end
          break;
        end else if (tbl_energy[order[i]] < e) begin
          s = worst_slot;
          st = STAT_NEW_ENERGY;
          break;
        end
      end
    end

    case (st)
      STAT_REJECT: ;
      STAT_DUPLICATE: begin
        if (tbl_hits[s] != HIT_MAX) tbl_hits[s] = tbl_hits[s] + HIT_ONE;
      end
      default: begin
        tbl_energy[s] = e;
        tbl_bits[s]   = bits;
        tbl_hits[s]   = HIT_ONE;
      end
    endcase

    rank_slots(order);
    r.status      = st;
    r.hit_count   = (st == STAT_REJECT) ? '0 : tbl_hits[s];
    r.equals_best = (st != STAT_REJECT) && (e == tbl_energy[order[0]]);
    r.slot        = (st == STAT_REJECT) ? '0 : OUT_SLOT_W'(s);
    return r;
  endfunction

  function automatic logic signed [ENERGY_W-1:0] nudge_energy(
      logic signed [ENERGY_W-1:0] base, int delta);
    longint v;
    v = base;
    v = v + delta;
    if (v > longint'(E_MAX)) v = E_MAX;
    if (v < longint'(E_MIN)) v = E_MIN;
    return ENERGY_W'(v);
  endfunction

  // Random candidate, weighted towards the energies and vectors already stored so that
  // duplicates, equal-energy runs and fresh bests keep turning up.
  function automatic sol_in_t pick_candidate();
    sol_in_t                  w;
    int                       order [TABLE_ENTRIES];
    int                       k;
    logic [SOLUTION_BITS-1:0] pool_bits;
    k = $urandom_range(0, TABLE_ENTRIES - 1);
    rank_slots(order);
    w.solution_bits = {$urandom, $urandom};
    w.energy = $urandom;
    case ($urandom_range(0, 3))
      0: pool_bits = '0;
      1: pool_bits = '1;
      2: pool_bits = SOLUTION_BITS'($urandom_range(0, 15));
      default: pool_bits = w.solution_bits[SOLUTION_BITS-1:0];
    endcase
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4: begin
        w.solution_bits = tbl_bits[k];
        w.energy = tbl_energy[k];
      end
      5, 6, 7, 8, 9: begin
        w.solution_bits = pool_bits;
        w.energy = tbl_energy[k];
      end
      10, 11, 12, 13: begin
        w.solution_bits = pool_bits;
        w.energy = nudge_energy(tbl_energy[k], int'($urandom_range(0, 6)) - 3);
      end
      14, 15, 16: begin
        w.solution_bits = pool_bits;
        w.energy = nudge_energy(tbl_energy[order[0]], int'($urandom_range(1, 3)));
      end
      default: ;
    endcase
    return w;
  endfunction

  task automatic report_mismatch(string field, int got, int want);
    if (mismatches < REPORT_CAP)
      $display("mismatch in %s on result %0d: got %0d, want %0d",
               field, results_seen, got, want);
    mismatches++;
  endtask

  // Offer one word; entered and left at a falling edge. The expectation is queued
  // at the edge that accepts the word.
  task automatic offer_word(sol_in_t w, bit use_typed, sol_out_t typed_want);
    int       gap;
    sol_out_t predicted;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predicted = grade_solution(w);
    pending_results.push_back(use_typed ? typed_want : predicted);
    @(negedge clk);
  endtask

  task automatic walk_rows(int first, int last);
    sol_in_t w;
    for (int r = first; r <= last; r++) begin
      w.solution_bits = STIM_ROWS[r].bits;
      w.energy        = STIM_ROWS[r].energy;
      // run long repeats flat out to keep the cycle count down
      no_idle = (STIM_ROWS[r].reps > 1);
      for (int n = 1; n <= STIM_ROWS[r].reps; n++)
        offer_word(w, STIM_ROWS[r].typed && (n == STIM_ROWS[r].reps), STIM_ROWS[r].want);
    end
  endtask

  // Result side: stall at random, hold off once for a long stretch so the block
  // backs up into its input, then compare each word with the oldest expectation.
  initial begin : drain_results
    int       stall;
    sol_out_t want;
    out_ready = 1'b0;
    results_seen = 0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if (squeeze_pending) begin
        squeeze_pending = 1'b0;
        out_ready <= 1'b0;
        repeat (SQUEEZE_CYCLES) @(negedge clk);
      end
      stall = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word, status", int'(out_word.status), -1);
      end else begin
        want = pending_results.pop_front();
        if (out_word.status !== want.status)
          report_mismatch("status", int'(out_word.status), int'(want.status));
        if (out_word.hit_count !== want.hit_count)
          report_mismatch("hit_count", int'(out_word.hit_count), int'(want.hit_count));
        if (out_word.equals_best !== want.equals_best)
          report_mismatch("equals_best", int'(out_word.equals_best), int'(want.equals_best));
        if (out_word.slot !== want.slot)
          report_mismatch("slot", int'(out_word.slot), int'(want.slot));
      end
      @(negedge clk);
    end
  end

  // Give up on a hang.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles <= CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin : run_stimulus
    sol_in_t w;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_word         = '0;
    no_idle         = 1'b0;
    squeeze_pending = 1'b0;
    mismatches      = 0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      tbl_energy[i] = ENERGY_RESET;
      tbl_bits[i]   = '0;
      tbl_hits[i]   = '0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    walk_rows(0, OPENING_ROWS - 1);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      // leave a couple of stretches with no idling on either side
      no_idle = (i >= 300 && i < 420) || (i >= 1100 && i < 1180);
      if (i == SQUEEZE_AT) squeeze_pending = 1'b1;
      w = pick_candidate();
      offer_word(w, 1'b0, UNTYPED);
    end

    walk_rows(OPENING_ROWS, NUM_ROWS - 1);
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_results.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/bst_pkg.sv
hw/rtl/best_solutions_table.sv
tb/tb.sv
